>>> rtl/core/trfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trfp_pkg
// Types and constants shared by the touch response frame parser.
// ----------------------------------------------------------------------------
package trfp_pkg;

  // Frame and command codes.
  localparam logic [7:0] FRAME_START = 8'hEE;
  localparam logic [7:0] CMD_ACT     = 8'h01;
  localparam logic [7:0] CMD_TOUCH   = 8'h04;
  localparam logic [7:0] CMD_LED     = 8'h1C;

  // Bytes in one touch point and in one LED entry.
  localparam logic [2:0] POINT_BYTES = 3'd7;
  localparam logic [2:0] LED_BYTES   = 3'd3;

  // Most results that one input byte can cause.
  localparam int unsigned MAX_RES = 3;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_WAIT,
    PH_SIZE,
    PH_CMD,
    PH_COUNT,
    PH_LEDY,
    PH_RECS,
    PH_SKIP
  } phase_e;

  // Result record kinds.
  typedef enum logic [2:0] {
    KIND_POINT      = 3'd0,
    KIND_REPORT_END = 3'd1,
    KIND_LED_HEADER = 3'd2,
    KIND_LED_ENTRY  = 3'd3,
    KIND_ACT_FAULT  = 3'd4,
    KIND_BAD_START  = 3'd5,
    KIND_TRUNCATED  = 3'd6
  } kind_e;

  // One result record.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pressure;
    logic [7:0]  probability;
    logic        multi_touch;
    logic        led_axis;
    logic [7:0]  item_count;
    logic [23:0] led_entry;
    logic        last;
  } res_t;

  // A record of the given kind with every other field cleared.
  function automatic res_t mk_rec(kind_e kind);
    res_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/touch_response_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_response_frame_parser
// Parses the touch controller's byte stream into point, LED and error records.
// ----------------------------------------------------------------------------
// One response byte is taken per transfer and parsed in the same cycle into
// zero to three result records, which are loaded into a three-entry result
// buffer and handed out one per cycle while the output is not stalled. A byte
// that causes at most one result lets bytes follow each other in every cycle
// while the output side keeps up; a byte that causes two or three results
// holds the input while the buffer drains. Only the result buffer sets the
// rate.
module touch_response_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [15:0]      pos_x_o,
  output logic [15:0]      pos_y_o,
  output logic [15:0]      pressure_o,
  output logic [7:0]       probability_o,
  output logic             multi_touch_o,
  output logic             led_axis_o,
  output logic [7:0]       item_count_o,
  output logic [23:0]      led_entry_o,
  output logic             last_o
);
  import trfp_pkg::*;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [7:0]  start_byte_q, start_byte_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  command_code_q, command_code_d;
  logic [7:0]  records_total_q, records_total_d;
  logic [7:0]  records_done_q, records_done_d;
  logic [2:0]  byte_in_record_q, byte_in_record_d;
  logic [7:0]  y_led_count_q, y_led_count_d;
  logic        current_axis_q, current_axis_d;
  logic [55:0] record_shift_q, record_shift_d;

  // Result buffer; entry 0 is the one on the output.
  res_t        res_q [MAX_RES];
  logic [1:0]  res_cnt_q;

  // Results of the byte on the input.
  res_t        new_res [MAX_RES];
  logic [1:0]  new_cnt;

  logic        in_accept;
  logic        out_take;

  // Work variables of the parser logic.
  logic        frame_end;
  logic        start_y;
  logic        touch_cmd;
  logic [2:0]  rec_size;
  logic [55:0] rec_word;
  logic        multi;
  res_t        rec;

  assign out_valid_o = (res_cnt_q != 2'd0);
  assign out_take    = out_valid_o && !out_stall_i;
  // A new byte may come in once the buffer empties in this cycle.
  assign in_stall_o  = (res_cnt_q > 2'd1) || ((res_cnt_q == 2'd1) && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;

  // Parse one byte: next state and the results it causes.
  always_comb begin
    phase_d          = phase_q;
    start_byte_d     = start_byte_q;
    bytes_left_d     = bytes_left_q;
    command_code_d   = command_code_q;
    records_total_d  = records_total_q;
    records_done_d   = records_done_q;
    byte_in_record_d = byte_in_record_q;
    y_led_count_d    = y_led_count_q;
    current_axis_d   = current_axis_q;
    record_shift_d   = record_shift_q;
    for (int i = 0; i < MAX_RES; i++) begin
      new_res[i] = '0;
    end
    new_cnt   = 2'd0;
    frame_end = 1'b0;
    start_y   = 1'b0;
    touch_cmd = (command_code_q == CMD_TOUCH);
    rec_size  = touch_cmd ? POINT_BYTES : LED_BYTES;
    rec_word  = '0;
    multi     = (records_total_q >= 8'd2);
    rec       = '0;

    case (phase_q)
      PH_SIZE: begin
        if (start_byte_q != FRAME_START) begin
          new_res[new_cnt] = mk_rec(KIND_BAD_START);
          new_cnt          = new_cnt + 2'd1;
          phase_d          = PH_WAIT;
        end else if (data_byte_i == 8'd0) begin
          phase_d = PH_WAIT;
        end else begin
          bytes_left_d = data_byte_i;
          phase_d      = PH_CMD;
        end
      end
      PH_CMD, PH_COUNT, PH_LEDY, PH_RECS, PH_SKIP: begin
        bytes_left_d = bytes_left_q - 8'd1;
        frame_end    = (bytes_left_d == 8'd0);
        case (phase_q)
          PH_CMD: begin
            command_code_d = data_byte_i;
            if (data_byte_i == CMD_TOUCH || data_byte_i == CMD_LED ||
                data_byte_i == CMD_ACT) begin
              phase_d = PH_COUNT;
            end else begin
              phase_d = PH_SKIP;
            end
          end
          PH_COUNT: begin
            if (command_code_q == CMD_TOUCH) begin
              records_total_d  = data_byte_i;
              records_done_d   = 8'd0;
              byte_in_record_d = 3'd0;
              record_shift_d   = '0;
              if (data_byte_i == 8'd0) begin
                new_res[new_cnt] = mk_rec(KIND_REPORT_END);
                new_cnt          = new_cnt + 2'd1;
                phase_d          = PH_SKIP;
              end else begin
                phase_d = PH_RECS;
              end
            end else if (command_code_q == CMD_LED) begin
              records_total_d = data_byte_i;
              phase_d         = PH_LEDY;
            end else begin
              if (data_byte_i != 8'd0) begin
                new_res[new_cnt] = mk_rec(KIND_ACT_FAULT);
                new_cnt          = new_cnt + 2'd1;
              end
              phase_d = PH_SKIP;
            end
          end
          PH_LEDY: begin
            y_led_count_d    = data_byte_i;
            current_axis_d   = 1'b0;
            records_done_d   = 8'd0;
            byte_in_record_d = 3'd0;
            record_shift_d   = '0;
            rec              = mk_rec(KIND_LED_HEADER);
            rec.item_count   = records_total_q;
            new_res[new_cnt] = rec;
            new_cnt          = new_cnt + 2'd1;
            if (records_total_q == 8'd0) begin
              start_y = 1'b1;
            end else begin
              phase_d = PH_RECS;
            end
          end
          PH_RECS: begin
            // Gather the byte into the current record.
            rec_word = record_shift_q;
            if (byte_in_record_q >= rec_size) begin
              byte_in_record_d = 3'd0;
              rec_word         = '0;
            end else begin
              byte_in_record_d = byte_in_record_q;
            end
            rec_word         = rec_word |
                               ({48'd0, data_byte_i} << {byte_in_record_d, 3'b000});
            byte_in_record_d = byte_in_record_d + 3'd1;
            record_shift_d   = rec_word;
            if (byte_in_record_d == rec_size) begin
              byte_in_record_d = 3'd0;
              record_shift_d   = '0;
              records_done_d   = records_done_q + 8'd1;
              if (touch_cmd) begin
                rec              = mk_rec(KIND_POINT);
                rec.pos_x        = rec_word[15:0];
                rec.pos_y        = rec_word[31:16];
                rec.pressure     = rec_word[47:32];
                rec.probability  = rec_word[55:48];
                rec.multi_touch  = multi;
                rec.item_count   = records_total_q;
                new_res[new_cnt] = rec;
                new_cnt          = new_cnt + 2'd1;
                if (records_done_d == records_total_q) begin
                  rec              = mk_rec(KIND_REPORT_END);
                  rec.multi_touch  = multi;
                  rec.item_count   = records_total_q;
                  new_res[new_cnt] = rec;
                  new_cnt          = new_cnt + 2'd1;
                  phase_d          = PH_SKIP;
                end
              end else begin
                rec              = mk_rec(KIND_LED_ENTRY);
                rec.led_axis     = current_axis_q;
                rec.item_count   = records_total_q;
                rec.led_entry    = rec_word[23:0];
                new_res[new_cnt] = rec;
                new_cnt          = new_cnt + 2'd1;
                if (records_done_d == records_total_q) begin
                  if (!current_axis_q) begin
                    start_y = 1'b1;
                  end else begin
                    phase_d = PH_SKIP;
                  end
                end
              end
            end
          end
          default: begin
          end
        endcase

        // Open the y axis of an LED frame.
        if (start_y) begin
          current_axis_d   = 1'b1;
          records_total_d  = y_led_count_d;
          records_done_d   = 8'd0;
          byte_in_record_d = 3'd0;
          record_shift_d   = '0;
          rec              = mk_rec(KIND_LED_HEADER);
          rec.led_axis     = 1'b1;
          rec.item_count   = y_led_count_d;
          new_res[new_cnt] = rec;
          new_cnt          = new_cnt + 2'd1;
          phase_d          = (y_led_count_d == 8'd0) ? PH_SKIP : PH_RECS;
        end

        // The frame is over: flag it when more was still expected.
        if (frame_end) begin
          if (phase_d != PH_SKIP) begin
            new_res[new_cnt] = mk_rec(KIND_TRUNCATED);
            new_cnt          = new_cnt + 2'd1;
          end
          phase_d = PH_WAIT;
        end
      end
      default: begin
        start_byte_d = data_byte_i;
        phase_d      = PH_SIZE;
      end
    endcase

    // Mark the final result of this byte.
    if (new_cnt != 2'd0) begin
      new_res[new_cnt - 2'd1].last = 1'b1;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_WAIT;
      start_byte_q     <= '0;
      bytes_left_q     <= '0;
      command_code_q   <= '0;
      records_total_q  <= '0;
      records_done_q   <= '0;
      byte_in_record_q <= '0;
      y_led_count_q    <= '0;
      current_axis_q   <= 1'b0;
      record_shift_q   <= '0;
    end else if (in_accept) begin
      phase_q          <= phase_d;
      start_byte_q     <= start_byte_d;
      bytes_left_q     <= bytes_left_d;
      command_code_q   <= command_code_d;
      records_total_q  <= records_total_d;
      records_done_q   <= records_done_d;
      byte_in_record_q <= byte_in_record_d;
      y_led_count_q    <= y_led_count_d;
      current_axis_q   <= current_axis_d;
      record_shift_q   <= record_shift_d;
    end
  end

  // Result buffer fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
    end else if (in_accept) begin
      res_cnt_q <= new_cnt;
    end else if (out_take) begin
      res_cnt_q <= res_cnt_q - 2'd1;
    end
  end

  // Result buffer contents: load on a new byte, else move up on a transfer.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_q[i] <= new_res[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        res_q[i] <= res_q[i + 1];
      end
    end
  end

  // Output fields from the head of the buffer.
  assign kind_o        = res_q[0].kind;
  assign pos_x_o       = res_q[0].pos_x;
  assign pos_y_o       = res_q[0].pos_y;
  assign pressure_o    = res_q[0].pressure;
  assign probability_o = res_q[0].probability;
  assign multi_touch_o = res_q[0].multi_touch;
  assign led_axis_o    = res_q[0].led_axis;
  assign item_count_o  = res_q[0].item_count;
  assign led_entry_o   = res_q[0].led_entry;
  assign last_o        = res_q[0].last;

  // Error records always close the results of their byte.
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_BAD_START || kind_o == KIND_TRUNCATED) |-> last_o)
    else $error("error record not marked last");

  // A point record is multi-touch exactly when the frame has two or more points.
  a_point_multi : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_POINT |-> multi_touch_o == (item_count_o >= 8'd2))
    else $error("multi-touch flag disagrees with point count");

  // The size byte either opens the payload or returns to waiting for a start.
  a_size_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && phase_q == PH_SIZE |=> phase_q == PH_WAIT || phase_q == PH_CMD)
    else $error("bad phase after size byte");

  // Only the final buffered record carries the last flag.
  a_last_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> res_cnt_q == 2'd1)
    else $error("last flag on a record that is not the final one");

`default_nettype wire
endmodule

>>> tb/sv/touch_response_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// touch_response_frame_parser_tb
// Self-checking bench for the touch controller response frame parser. A small
// checker class mirrors the parser state and predicts every record for each
// byte transfer. Directed frames cover the edge cases first. Random frames
// follow: well-formed, truncated, padded and broken, with varied idling on both
// sides.
// ----------------------------------------------------------------------------
module touch_response_frame_parser_tb;
  import trfp_pkg::*;

  // Mirrors the parser state and keeps the records still owed by the block.
  class frame_record_checker;
    phase_e      ph;
    logic [7:0]  start_b;
    logic [7:0]  bytes_rem;
    logic [7:0]  cmd;
    logic [7:0]  total;
    logic [7:0]  done;
    logic [7:0]  y_count;
    logic [2:0]  in_rec;
    logic        axis;
    logic [55:0] shift;
    res_t        records_due[$];
    res_t        this_byte[$];
    int          errors;

    function new();
      ph        = PH_WAIT;
      start_b   = '0;
      bytes_rem = '0;
      cmd       = '0;
      total     = '0;
      done      = '0;
      y_count   = '0;
      in_rec    = '0;
      axis      = 1'b0;
      shift     = '0;
      errors    = 0;
    endfunction

    function int pending();
      return records_due.size();
    endfunction

    // Builds one record for the current byte; unused fields stay zero.
    function void add(input kind_e k, input logic [15:0] x, input logic [15:0] y,
                      input logic [15:0] p, input logic [7:0] prob, input logic mt,
                      input logic ax, input logic [7:0] cnt, input logic [23:0] entry);
      res_t r;
      if (this_byte.size() >= MAX_RES) return;
      r             = '0;
      r.kind        = k;
      r.pos_x       = x;
      r.pos_y       = y;
      r.pressure    = p;
      r.probability = prob;
      r.multi_touch = mt;
      r.led_axis    = ax;
      r.item_count  = cnt;
      r.led_entry   = entry;
      this_byte.push_back(r);
    endfunction

    // Switches from the x LED entries to the y ones.
    function void open_y_axis();
      axis   = 1'b1;
      total  = y_count;
      done   = '0;
      in_rec = '0;
      shift  = '0;
      add(KIND_LED_HEADER, 0, 0, 0, 0, 1'b0, 1'b1, total, 0);
      if (total == 0) begin
        ph = PH_SKIP;
      end else begin
        ph = PH_RECS;
      end
    endfunction

    // Collects one byte of a touch point or an LED entry.
    function void take_record_byte(input logic [7:0] b);
      logic        touch;
      logic [2:0]  size;
      logic [55:0] r;
      logic        multi;
      touch = (cmd == CMD_TOUCH);
      size  = touch ? POINT_BYTES : LED_BYTES;
      if (in_rec >= size) begin
        in_rec = '0;
        shift  = '0;
      end
      shift  = shift | (56'(b) << (8 * in_rec));
      in_rec = in_rec + 3'd1;
      if (in_rec < size) return;
      r      = shift;
      in_rec = '0;
      shift  = '0;
      done   = done + 8'd1;
      multi  = (total >= 8'd2);
      if (touch) begin
        add(KIND_POINT, r[15:0], r[31:16], r[47:32], r[55:48], multi, 1'b0, total, 0);
        if (done == total) begin
          add(KIND_REPORT_END, 0, 0, 0, 0, multi, 1'b0, total, 0);
          ph = PH_SKIP;
        end
      end else begin
        add(KIND_LED_ENTRY, 0, 0, 0, 0, 1'b0, axis, total, r[23:0]);
        if (done == total) begin
          if (axis == 1'b0) begin
            open_y_axis();
          end else begin
            ph = PH_SKIP;
          end
        end
      end
    endfunction

    // Works out the records caused by one accepted byte.
    function void note_byte(input logic [7:0] b);
      logic fin;
      res_t r;
      this_byte.delete();
      if (ph == PH_SIZE) begin
        if (start_b != FRAME_START) begin
          add(KIND_BAD_START, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0);
          ph = PH_WAIT;
        end else if (b == 0) begin
          ph = PH_WAIT;
        end else begin
          bytes_rem = b;
          ph        = PH_CMD;
        end
      end else if (ph != PH_WAIT) begin
        bytes_rem = bytes_rem - 8'd1;
        fin       = (bytes_rem == 0);
        case (ph)
          PH_CMD: begin
            cmd = b;
            if (b == CMD_TOUCH || b == CMD_LED || b == CMD_ACT) begin
              ph = PH_COUNT;
            end else begin
              ph = PH_SKIP;
            end
          end
          PH_COUNT: begin
            if (cmd == CMD_TOUCH) begin
              total  = b;
              done   = '0;
              in_rec = '0;
              shift  = '0;
              if (b == 0) begin
                add(KIND_REPORT_END, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0);
                ph = PH_SKIP;
              end else begin
                ph = PH_RECS;
              end
            end else if (cmd == CMD_LED) begin
              total = b;
              ph    = PH_LEDY;
            end else begin
              if (b != 0) add(KIND_ACT_FAULT, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0);
              ph = PH_SKIP;
            end
          end
          PH_LEDY: begin
            y_count = b;
            axis    = 1'b0;
            done    = '0;
            in_rec  = '0;
            shift   = '0;
            add(KIND_LED_HEADER, 0, 0, 0, 0, 1'b0, 1'b0, total, 0);
            if (total == 0) begin
              open_y_axis();
            end else begin
              ph = PH_RECS;
            end
          end
          PH_RECS: take_record_byte(b);
          default: ;
        endcase
        // The frame ends here; anything still outstanding means truncation.
        if (fin) begin
          if (ph != PH_SKIP) add(KIND_TRUNCATED, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0);
          ph = PH_WAIT;
        end
      end else begin
        start_b = b;
        ph      = PH_SIZE;
      end
      // Mark the final record of this byte and queue them all.
      if (this_byte.size() > 0) begin
        r      = this_byte.pop_back();
        r.last = 1'b1;
        this_byte.push_back(r);
      end
      foreach (this_byte[i]) records_due.push_back(this_byte[i]);
    endfunction

    function void compare_field(input string name, input logic [23:0] want,
                                input logic [23:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    // Checks one accepted record against the oldest one owed.
    function void check_record(input res_t got);
      res_t want;
      if (records_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected record: expected none, got kind %0d", $time, got.kind);
        return;
      end
      want = records_due.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("pressure", want.pressure, got.pressure);
      compare_field("probability", want.probability, got.probability);
      compare_field("multi_touch", want.multi_touch, got.multi_touch);
      compare_field("led_axis", want.led_axis, got.led_axis);
      compare_field("item_count", want.item_count, got.item_count);
      compare_field("led_entry", want.led_entry, got.led_entry);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [15:0] pos_x_o;
  logic [15:0] pos_y_o;
  logic [15:0] pressure_o;
  logic [7:0]  probability_o;
  logic        multi_touch_o;
  logic        led_axis_o;
  logic [7:0]  item_count_o;
  logic [23:0] led_entry_o;
  logic        last_o;

  frame_record_checker checker_h;
  logic [7:0]          payload[$];
  int                  bytes_sent;
  int                  snd_idle_pct;
  int                  rcv_stall_pct;

  touch_response_frame_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pressure_o    (pressure_o),
    .probability_o (probability_o),
    .multi_touch_o (multi_touch_o),
    .led_axis_o    (led_axis_o),
    .item_count_o  (item_count_o),
    .led_entry_o   (led_entry_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: check each transfer, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind        = kind_e'(kind_o);
      got.pos_x       = pos_x_o;
      got.pos_y       = pos_y_o;
      got.pressure    = pressure_o;
      got.probability = probability_o;
      got.multi_touch = multi_touch_o;
      got.led_axis    = led_axis_o;
      got.item_count  = item_count_o;
      got.led_entry   = led_entry_o;
      got.last        = last_o;
      checker_h.check_record(got);
    end
    out_stall_i <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // Holds the sender back until every owed record has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (checker_h.pending() != 0);
  endtask

  // Offers one byte, with an optional idle gap first, and waits for the transfer.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if ($urandom_range(0, 49) == 0) begin
      wait_drained();
    end else begin
      while ($urandom_range(0, 99) < snd_idle_pct) gap++;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    checker_h.note_byte(b);
    bytes_sent++;
  endtask

  // Sends a frame header and size bytes of payload, padding with noise.
  task automatic send_frame(input int size);
    send_byte(FRAME_START);
    send_byte(size[7:0]);
    for (int i = 0; i < size; i++) begin
      if (i < payload.size()) begin
        send_byte(payload[i]);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // A fill below zero means random point bytes.
  function automatic void make_touch(input int n, input int fill);
    payload = {CMD_TOUCH, n[7:0]};
    for (int i = 0; i < 7 * n; i++) begin
      payload.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0]);
    end
  endfunction

  function automatic void make_led(input int nx, input int ny);
    payload = {CMD_LED, nx[7:0], ny[7:0]};
    for (int i = 0; i < 3 * (nx + ny); i++) payload.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic int rare_count();
    if ($urandom_range(0, 11) == 0) return $urandom_range(5, 255);
    return $urandom_range(0, 4);
  endfunction

  // Random frames: mostly well-formed, some truncated, padded or broken.
  task automatic run_random(input int n);
    int target;
    int sel;
    int len;
    int size;
    logic [7:0] b;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 85 && sel >= 75) begin
        // Broken header: any start byte but the right one.
        do b = 8'($urandom_range(0, 255)); while (b == FRAME_START);
        send_byte(b);
        send_byte(8'($urandom_range(0, 255)));
      end else if (sel >= 85 && sel < 90) begin
        send_frame(0);
      end else if (sel >= 90) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        if (sel < 30) begin
          make_touch(rare_count(), -1);
        end else if (sel < 55) begin
          make_led(rare_count(), rare_count());
        end else if (sel < 65) begin
          payload = {CMD_ACT, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom)};
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (b == CMD_ACT || b == CMD_TOUCH || b == CMD_LED);
          payload = {b};
          repeat ($urandom_range(0, 5)) payload.push_back(8'($urandom_range(0, 255)));
        end
        len = payload.size();
        sel = $urandom_range(0, 99);
        if (len > 40) begin
          size = $urandom_range(3, 40);
        end else if (sel < 15 && len > 1) begin
          size = $urandom_range(1, len - 1);
        end else if (sel < 30) begin
          size = len + $urandom_range(1, 4);
        end else begin
          size = len;
        end
        send_frame(size);
      end
    end
  endtask

  initial begin
    checker_h     = new();
    bytes_sent    = 0;
    snd_idle_pct  = 20;
    rcv_stall_pct = 74;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    data_byte_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Touch frames: all-ones point, two all-zero points, no points.
    make_touch(1, 255);
    send_frame(payload.size());
    make_touch(2, 0);
    send_frame(payload.size());
    make_touch(0, 0);
    send_frame(payload.size());
    // LED frames: one per axis, both empty, empty x axis, a huge x count cut short.
    make_led(1, 1);
    send_frame(payload.size());
    make_led(0, 0);
    send_frame(payload.size());
    make_led(0, 1);
    send_frame(payload.size());
    make_led(255, 0);
    send_frame(11);
    // Activation replies: clean, and faulty with surplus bytes.
    payload = {CMD_ACT, 8'h00};
    send_frame(2);
    payload = {CMD_ACT, 8'h80};
    send_frame(4);
    // Unknown command, bad start, empty frame.
    payload = {8'h55, 8'hAA};
    send_frame(2);
    send_byte(8'h12);
    send_byte(8'h34);
    send_frame(0);
    // Frames cut before the count, inside a point, and before the y count.
    make_touch(1, -1);
    send_frame(1);
    send_frame(5);
    make_led(2, 2);
    send_frame(2);
    wait_drained();

    run_random(65);
    wait_drained();
    snd_idle_pct  = 74;
    rcv_stall_pct = 20;
    run_random(65);
    wait_drained();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    run_random(65);

    // Let everything owed arrive, then watch for stray records.
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (checker_h.errors == 0 && checker_h.pending() == 0) begin
      $display("touch_response_frame_parser_tb: PASS");
    end else begin
      $display("touch_response_frame_parser_tb: FAIL");
    end
    $finish;
  end

  // Timeout for a run that hangs.
  initial begin
    #4000000;
    $display("touch_response_frame_parser_tb: FAIL");
    $finish;
  end

endmodule

>>> touch_response_frame_parser.f
rtl/core/trfp_pkg.sv
rtl/core/touch_response_frame_parser.sv
tb/sv/touch_response_frame_parser_tb.sv
